>>> rtl/core/mpq2k_pkg.sv
package mpq2k_pkg;

    // Request kinds on s_tuser; any other code behaves as a peek.
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_PEEK   = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;

    localparam int REC_W   = 42;
    localparam int TDATA_W = 48;

    // Packed with name_id in the low bits, matching tdata.
    typedef struct packed {
        logic [9:0]  marks;
        logic [15:0] roll;
        logic [15:0] name_id;
    } rec_t;

    // Controller to datapath.
    typedef struct packed {
        logic load_req;   // capture request
        logic check;      // latch dropped flag
        logic start_ins;  // j <= count, read slot count-1
        logic shift;      // move read entry down one slot, j--
        logic place;      // write new record at slot j, count++
        logic remove;     // pop head, read new top
        logic load_top;   // top <= read data
        logic load_out;   // fill output register
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic [1:0] req_type;
        logic       full;
        logic       empty;
        logic       outranks;  // new record beats the entry just read
        logic       j_one;
    } status_t;

endpackage

>>> rtl/core/mpq2k_ram.sv
module mpq2k_ram #(
    parameter int WIDTH = 42,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/mpq2k_datapath.sv
module mpq2k_datapath #(
    parameter int CAPACITY = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  mpq2k_pkg::cmd_t              cmd,
    output mpq2k_pkg::status_t           status,
    input  logic [1:0]                   in_req_type,
    input  mpq2k_pkg::rec_t              in_rec,
    output logic [mpq2k_pkg::TDATA_W-1:0] out_tdata,
    output logic [1:0]                   out_tuser
);
    import mpq2k_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [AW:0]   CAP_A = (AW + 1)'(CAPACITY);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    // Entries sit in rank order in a circular buffer starting at head.
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] j_reg, j_next;
    logic [1:0]    req_reg;
    rec_t          rec_reg;
    rec_t          top_reg, top_next;
    logic          drop_reg;
    rec_t          out_rec_reg;
    logic [1:0]    out_user_reg;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    rec_t          wdata;
    logic [REC_W-1:0] rdata;
    rec_t          rd_rec;
    logic [CW-1:0] cnt_m1;
    logic [AW-1:0] j_m2;

    // Logical slot to RAM address.
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] h,
                                           input logic [AW-1:0] l);
        logic [AW:0] s;
        s = {1'b0, h} + {1'b0, l};
        if (s >= CAP_A) begin
            s = s - CAP_A;
        end
        return s[AW-1:0];
    endfunction

    assign rd_rec = rec_t'(rdata);
    assign cnt_m1 = count_reg - CW'(1);
    assign j_m2   = (j_reg >= AW'(2)) ? j_reg - AW'(2) : '0;

    mpq2k_ram #(
        .WIDTH (REC_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb begin
        raddr = phys(head_reg, j_m2);
        if (cmd.start_ins) begin
            raddr = phys(head_reg, cnt_m1[AW-1:0]);
        end else if (cmd.remove) begin
            raddr = phys(head_reg, AW'(1));
        end
        we    = cmd.shift | cmd.place;
        waddr = phys(head_reg, j_reg);
        wdata = cmd.shift ? rd_rec : rec_reg;
    end

    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        j_next     = j_reg;
        top_next   = top_reg;
        if (cmd.start_ins) begin
            j_next = count_reg[AW-1:0];
        end
        if (cmd.shift) begin
            j_next = j_reg - AW'(1);
        end
        if (cmd.place) begin
            count_next = count_reg + CW'(1);
            if (j_reg == '0) begin
                top_next = rec_reg;
            end
        end
        if (cmd.remove) begin
            head_next  = phys(head_reg, AW'(1));
            count_next = count_reg - CW'(1);
        end
        if (cmd.load_top) begin
            top_next = rd_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        j_reg   <= j_next;
        top_reg <= top_next;
        if (cmd.load_req) begin
            req_reg <= in_req_type;
            rec_reg <= in_rec;
        end
        if (cmd.check) begin
            drop_reg <= (req_reg == REQ_INSERT) && (count_reg == CAP_C);
        end
        if (cmd.load_out) begin
            out_rec_reg  <= (count_reg == '0) ? rec_t'('0) : top_reg;
            out_user_reg <= {drop_reg, count_reg == '0};
        end
    end

    always_comb begin
        status.req_type = req_reg;
        status.full     = (count_reg == CAP_C);
        status.empty    = (count_reg == '0);
        status.outranks = (rec_reg.marks > rd_rec.marks) ||
                          ((rec_reg.marks == rd_rec.marks) && (rec_reg.roll < rd_rec.roll));
        status.j_one    = (j_reg == AW'(1));
    end

    assign out_tdata = {(TDATA_W - REC_W)'(0), out_rec_reg};
    assign out_tuser = out_user_reg;

endmodule

>>> rtl/core/mpq2k_ctrl.sv
module mpq2k_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  mpq2k_pkg::status_t   status,
    output mpq2k_pkg::cmd_t      cmd,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready
);
    import mpq2k_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_EXEC  = 6'b000010,
        ST_CMP   = 6'b000100,
        ST_PLACE = 6'b001000,
        ST_TOP   = 6'b010000,
        ST_RESP  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   mvalid_reg, mvalid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.check = 1'b1;
                if (status.req_type == REQ_INSERT && !status.full) begin
                    cmd.start_ins = 1'b1;
                    state_next    = status.empty ? ST_PLACE : ST_CMP;
                end else if (status.req_type == REQ_REMOVE && !status.empty) begin
                    cmd.remove = 1'b1;
                    state_next = ST_TOP;
                end else begin
                    state_next = ST_RESP;
                end
            end
            ST_CMP: begin
                if (status.outranks) begin
                    cmd.shift  = 1'b1;
                    state_next = status.j_one ? ST_PLACE : ST_CMP;
                end else begin
                    cmd.place  = 1'b1;
                    state_next = ST_RESP;
                end
            end
            ST_PLACE: begin
                cmd.place  = 1'b1;
                state_next = ST_RESP;
            end
            ST_TOP: begin
                cmd.load_top = 1'b1;
                state_next   = ST_RESP;
            end
            ST_RESP: begin
                if (!mvalid_reg || m_tready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        mvalid_next = mvalid_reg;
        if (m_tready) begin
            mvalid_next = 1'b0;
        end
        if (cmd.load_out) begin
            mvalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mvalid_reg;

endmodule

>>> rtl/core/max_priority_queue_two_key.sv
// Bounded max priority queue of (name_id, roll, marks) records. A request on the
// s_ channel is an insert, a peek or a remove-top; each returns exactly one result
// on the m_ channel with the top record after the request (highest marks first,
// lower roll on equal marks, earliest insert on fully equal keys), or is_empty
// with zeroed fields. An insert into a full queue is dropped and flagged. Records
// are held sorted in one circular RAM buffer, so a remove is a head pointer bump
// and an insert walks up from the tail, moving one entry per cycle. One request
// at a time: each request passes ST_EXEC and ends in ST_RESP, which loads the
// result once the output register is free; a remove adds ST_TOP to read the new
// top, and an insert adds one ST_CMP shift per held record the new one outranks
// (up to CAPACITY-1), then its write in ST_CMP or ST_PLACE. The input is ready
// again in the cycle after the result is loaded.
// Results sit in an output register, so a new request is taken while one waits.
// No clearing pass is needed after reset.
module max_priority_queue_two_key #(
    parameter int CAPACITY = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // name_id[15:0], roll[31:16], marks[41:32], zero pad
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // top_name_id[15:0], top_roll[31:16], top_marks[41:32], pad
    output logic [1:0]  m_tuser    // is_empty[0], insert_dropped[1]
);
    import mpq2k_pkg::*;

    cmd_t    cmd;
    status_t status;
    rec_t    in_rec;

    // tdata layout matches rec_t packing
    assign in_rec = rec_t'(s_tdata[REC_W-1:0]);

    mpq2k_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .status   (status),
        .cmd      (cmd),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    mpq2k_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .in_req_type (s_tuser),
        .in_rec      (in_rec),
        .out_tdata   (m_tdata),
        .out_tuser   (m_tuser)
    );

endmodule

>>> rtl/core/mpq2k_checker.sv
module mpq2k_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // no result shows right after reset
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // empty result carries zero fields
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == 48'd0)
        else $error("empty result with nonzero fields");

    // a refused insert means the queue is full, so never empty
    a_drop_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> !m_tuser[0])
        else $error("dropped insert on empty queue");

    // one request in flight at a time
    a_one_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

endmodule

bind max_priority_queue_two_key mpq2k_checker u_chk (.*);
